// File: sv/tipc_pkg.sv
// Shared types and constants of the two-image pixel combiner.
package tipc_pkg;

	localparam int ChanWidth = 8;
	localparam int Stages = ChanWidth;
	localparam int WeightWidth = 9;
	localparam int IndexWidth = 2;
	localparam logic [WeightWidth-1:0] Q8One = 9'd256;
	localparam logic [WeightWidth-1:0] WeightReset = 9'd128;

	typedef enum logic [2:0] {
		MODE_AND   = 3'd0,
		MODE_OR    = 3'd1,
		MODE_AVG   = 3'd2,
		MODE_BLEND = 3'd3,
		MODE_SUB   = 3'd4,
		MODE_MUL   = 3'd5,
		MODE_DIV   = 3'd6
	} mode_t;

	localparam logic [IndexWidth-1:0] RegMode = 2'd0;
	localparam logic [IndexWidth-1:0] RegWeight = 2'd1;

	typedef struct packed {
		logic [2:0]             mode;
		logic [WeightWidth-1:0] weight;
	} cfg_t;

	typedef struct packed {
		logic [ChanWidth-1:0] a_red;
		logic [ChanWidth-1:0] a_green;
		logic [ChanWidth-1:0] a_blue;
		logic [ChanWidth-1:0] b_red;
		logic [ChanWidth-1:0] b_green;
		logic [ChanWidth-1:0] b_blue;
	} in_beat_t;

	typedef struct packed {
		logic [ChanWidth-1:0] out_red;
		logic [ChanWidth-1:0] out_green;
		logic [ChanWidth-1:0] out_blue;
	} out_beat_t;

endpackage

// File: sv/two_image_pixel_combiner.sv
// Top level of the two-image pixel combiner: config registers, stage control, three lanes.
//
// Usage: each input beat carries one RGB pixel of image A and one of image B.
// The three channels run in separate lanes with the operation chosen by the mode
// register (and, or, average, weighted blend, clamped subtract, product over 255,
// quotient). The result beat carries the three combined channels.
// Both channels use valid/stall; a beat moves when valid is high and stall low.
// Configuration: cfg_we writes cfg_data to register cfg_index (0 mode, 1 blend
// weight); other indexes are ignored. Write only while no pixel is in flight.
// Path: from the accepting edge a pixel passes 8 lane stages, set by the divider
// that resolves one quotient bit per stage, the first of them loaded at the
// accepting edge, and then the output register.
// Throughput: one pixel per clock while out_stall is low. Each stage advances when it
// is empty or the stage after it advances, so bubbles close up under a stall; when
// the receiver stalls, up to 9 pixels are held and then in_stall rises.
// Reset clears all stage valid bits, sets mode to 0 (and) and weight to 128.
module two_image_pixel_combiner (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_we,
	input  logic [tipc_pkg::IndexWidth-1:0]     cfg_index,
	input  logic [tipc_pkg::WeightWidth-1:0]    cfg_data,
	input  logic                                in_valid,
	output logic                                in_stall,
	input  tipc_pkg::in_beat_t                  in_data,
	output logic                                out_valid,
	input  logic                                out_stall,
	output tipc_pkg::out_beat_t                 out_data
);

	localparam int S = tipc_pkg::Stages;

	tipc_pkg::cfg_t cfg_q;
	logic [S-1:0] v_q;
	logic [S:0]   rdy;
	logic         take;
	logic [tipc_pkg::ChanWidth-1:0] red, green, blue;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.mode <= tipc_pkg::MODE_AND;
			cfg_q.weight <= tipc_pkg::WeightReset;
		end else if (cfg_we) begin
			case (cfg_index)
				tipc_pkg::RegMode: begin
					cfg_q.mode <= cfg_data[2:0];
				end
				tipc_pkg::RegWeight: begin
					cfg_q.weight <= cfg_data;
				end
				default: begin
				end
			endcase
		end
	end

	// A stage may load when it is empty or its contents move on this cycle.
	always_comb begin
		rdy[S] = take;
		for (int k = S - 1; k >= 0; k--) begin
			rdy[k] = !v_q[k] || rdy[k+1];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= '0;
		end else begin
			if (rdy[0]) begin
				v_q[0] <= in_valid;
			end
			for (int k = 1; k < S; k++) begin
				if (rdy[k]) begin
					v_q[k] <= v_q[k-1];
				end
			end
		end
	end

	assign in_stall = !rdy[0];

	tipc_lane u_lane_red (
		.clk    (clk),
		.cfg    (cfg_q),
		.en     (rdy[S-1:0]),
		.a      (in_data.a_red),
		.b      (in_data.b_red),
		.res    (red)
	);

	tipc_lane u_lane_green (
		.clk    (clk),
		.cfg    (cfg_q),
		.en     (rdy[S-1:0]),
		.a      (in_data.a_green),
		.b      (in_data.b_green),
		.res    (green)
	);

	tipc_lane u_lane_blue (
		.clk    (clk),
		.cfg    (cfg_q),
		.en     (rdy[S-1:0]),
		.a      (in_data.a_blue),
		.b      (in_data.b_blue),
		.res    (blue)
	);

	tipc_merge u_merge (
		.clk        (clk),
		.arst_n     (arst_n),
		.lane_valid (v_q[S-1]),
		.red        (red),
		.green      (green),
		.blue       (blue),
		.take       (take),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.out_data   (out_data)
	);

endmodule

// File: sv/tipc_lane.sv
// One channel lane: simple operations, blend and scaled multiply, and a divider
// that retires one quotient bit per stage.
module tipc_lane (
	input  logic                                  clk,
	input  tipc_pkg::cfg_t                        cfg,
	input  logic [tipc_pkg::Stages-1:0]           en,
	input  logic [tipc_pkg::ChanWidth-1:0]        a,
	input  logic [tipc_pkg::ChanWidth-1:0]        b,
	output logic [tipc_pkg::ChanWidth-1:0]        res
);

	localparam int W = tipc_pkg::ChanWidth;
	localparam int S = tipc_pkg::Stages;

	logic [W-1:0] rem_s [S];
	logic [W-1:0] dvd_s [S];
	logic [W-1:0] dvs_s [S];
	logic [W-1:0] res_s [S];

	logic [2*W-1:0] pw_s1, pb_s1, pm_s1;

	logic [tipc_pkg::WeightWidth-1:0] w_sat, w_inv;
	logic [tipc_pkg::WeightWidth+W-1:0] wa_full, wb_full;
	logic [2*W-1:0] ab_full;
	logic [W-1:0] simple;
	logic [W:0] avg_sum;
	logic [2*W:0] blend_sum, mul_sum;

	// Operations that fit in the first stage.
	always_comb begin
		w_sat = (cfg.weight > tipc_pkg::Q8One) ? tipc_pkg::Q8One : cfg.weight;
		w_inv = tipc_pkg::Q8One - w_sat;
		wa_full = w_sat * a;
		wb_full = w_inv * b;
		ab_full = a * b;
		avg_sum = {1'b0, a} + {1'b0, b};
		case (cfg.mode)
			tipc_pkg::MODE_AND: begin
				simple = a & b;
			end
			tipc_pkg::MODE_OR: begin
				simple = a | b;
			end
			tipc_pkg::MODE_AVG: begin
				simple = avg_sum[W:1];
			end
			tipc_pkg::MODE_SUB: begin
				simple = (a > b) ? a - b : '0;
			end
			default: begin
				simple = '0;
			end
		endcase
	end

	// Sum of the registered products; x/255 is (x + 1 + (x >> 8)) >> 8 for x up to 255*255.
	always_comb begin
		blend_sum = {1'b0, pw_s1} + {1'b0, pb_s1};
		mul_sum = {1'b0, pm_s1} + {{(W+1){1'b0}}, pm_s1[2*W-1:W]} + {{(2*W){1'b0}}, 1'b1};
	end

	always_ff @(posedge clk) begin
		if (en[0]) begin
			pw_s1 <= wa_full[2*W-1:0];
			pb_s1 <= wb_full[2*W-1:0];
			pm_s1 <= ab_full;
		end
	end

	for (genvar k = 0; k < S; k++) begin : g_stage
		logic [W-1:0] rem_in, dvd_in, dvs_in, res_in;
		logic [W:0]   trial;
		logic         ge;
		logic [W:0]   diff;

		if (k == 0) begin : g_first
			assign rem_in = '0;
			assign dvd_in = a;
			assign dvs_in = b;
			assign res_in = simple;
		end else if (k == 1) begin : g_second
			assign rem_in = rem_s[k-1];
			assign dvd_in = dvd_s[k-1];
			assign dvs_in = dvs_s[k-1];
			assign res_in = (cfg.mode == tipc_pkg::MODE_BLEND) ? blend_sum[2*W-1:W] :
				(cfg.mode == tipc_pkg::MODE_MUL) ? mul_sum[2*W-1:W] : res_s[k-1];
		end else begin : g_rest
			assign rem_in = rem_s[k-1];
			assign dvd_in = dvd_s[k-1];
			assign dvs_in = dvs_s[k-1];
			assign res_in = res_s[k-1];
		end

		// Restoring division step: bring down the next dividend bit.
		always_comb begin
			trial = {rem_in, dvd_in[W-1]};
			ge = trial >= {1'b0, dvs_in};
			diff = trial - {1'b0, dvs_in};
		end

		always_ff @(posedge clk) begin
			if (en[k]) begin
				rem_s[k] <= ge ? diff[W-1:0] : trial[W-1:0];
				dvd_s[k] <= {dvd_in[W-2:0], ge};
				dvs_s[k] <= dvs_in;
				res_s[k] <= res_in;
			end
		end
	end

	always_comb begin
		if (cfg.mode == tipc_pkg::MODE_DIV) begin
			res = (dvs_s[S-1] == '0) ? '0 : dvd_s[S-1];
		end else begin
			res = res_s[S-1];
		end
	end

endmodule

// File: sv/tipc_merge.sv
// Output stage: gathers the three lane results into one beat and holds it for the receiver.
module tipc_merge (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            lane_valid,
	input  logic [tipc_pkg::ChanWidth-1:0]  red,
	input  logic [tipc_pkg::ChanWidth-1:0]  green,
	input  logic [tipc_pkg::ChanWidth-1:0]  blue,
	output logic                            take,
	output logic                            out_valid,
	input  logic                            out_stall,
	output tipc_pkg::out_beat_t             out_data
);

	logic valid_q;
	tipc_pkg::out_beat_t data_q;

	assign take = !valid_q || !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (take) begin
			valid_q <= lane_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			data_q.out_red <= red;
			data_q.out_green <= green;
			data_q.out_blue <= blue;
		end
	end

	assign out_valid = valid_q;
	assign out_data = data_q;

endmodule

// File: tb/testbench.sv
// Self-checking testbench for the two-image pixel combiner: random stalls on both sides.
module testbench;

	localparam logic [2:0] ModeUnused = 3'd7;
	localparam logic [tipc_pkg::IndexWidth-1:0] RegSpareLow = 2'd2;
	localparam logic [tipc_pkg::IndexWidth-1:0] RegSpareHigh = 2'd3;
	localparam int PhaseCount = 16;
	localparam int PhaseBeats = 47;
	localparam int QuietLimit = 500;
	localparam int SettleCycles = 20;

	// Holds a copy of the two registers and the pixels still to come out of the block.
	class pixel_scoreboard;
		logic [2:0]                       mode;
		logic [tipc_pkg::WeightWidth-1:0] weight;
		tipc_pkg::out_beat_t              expected_pixels[$];
		int                               mismatches;

		function new();
			mode = tipc_pkg::MODE_AND;
			weight = tipc_pkg::WeightReset;
			mismatches = 0;
		endfunction

		function void set_reg(logic [tipc_pkg::IndexWidth-1:0] index,
				logic [tipc_pkg::WeightWidth-1:0] data);
			if (index == tipc_pkg::RegMode)
				mode = data[2:0];
			else if (index == tipc_pkg::RegWeight)
				weight = data;
		endfunction

		function logic [tipc_pkg::ChanWidth-1:0] mix_channel(
				logic [tipc_pkg::ChanWidth-1:0] a,
				logic [tipc_pkg::ChanWidth-1:0] b);
			logic [tipc_pkg::WeightWidth-1:0] w;
			logic [16:0]                      acc;
			logic [15:0]                      prod;
			logic [8:0]                       sum;
			case (mode)
				tipc_pkg::MODE_AND:   return a & b;
				tipc_pkg::MODE_OR:    return a | b;
				tipc_pkg::MODE_AVG: begin
					sum = {1'b0, a} + {1'b0, b};
					return sum[8:1];
				end
				tipc_pkg::MODE_BLEND: begin
					// Weights above one saturate, so the blend never leaves image A.
					w = (weight > tipc_pkg::Q8One) ? tipc_pkg::Q8One : weight;
					acc = 17'(w) * 17'(a) + 17'(tipc_pkg::Q8One - w) * 17'(b);
					return acc[15:8];
				end
				tipc_pkg::MODE_SUB:   return (a > b) ? a - b : '0;
				tipc_pkg::MODE_MUL: begin
					prod = 16'(a) * 16'(b);
					prod = prod / 16'd255;
					return prod[7:0];
				end
				tipc_pkg::MODE_DIV:   return (a == '0 || b == '0) ? '0 : a / b;
				default:              return '0;
			endcase
		endfunction

		function void note_pixel(tipc_pkg::in_beat_t px);
			tipc_pkg::out_beat_t res;
			res.out_red = mix_channel(px.a_red, px.b_red);
			res.out_green = mix_channel(px.a_green, px.b_green);
			res.out_blue = mix_channel(px.a_blue, px.b_blue);
			expected_pixels.push_back(res);
		endfunction

		function void check_pixel(tipc_pkg::out_beat_t got);
			tipc_pkg::out_beat_t want;
			if (expected_pixels.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("Unexpected output beat %h at %0t", got, $time);
				return;
			end
			want = expected_pixels.pop_front();
			if (got.out_red !== want.out_red || got.out_green !== want.out_green ||
					got.out_blue !== want.out_blue) begin
				mismatches++;
				if (mismatches <= 10)
					$display("Mismatch at %0t: expected r=%0d g=%0d b=%0d, got r=%0d g=%0d b=%0d",
						$time, want.out_red, want.out_green, want.out_blue,
						got.out_red, got.out_green, got.out_blue);
			end
		endfunction

		function int outstanding();
			return expected_pixels.size();
		endfunction
	endclass

	logic                             clk = 1'b0;
	logic                             arst_n = 1'b0;
	logic                             cfg_we = 1'b0;
	logic [tipc_pkg::IndexWidth-1:0]  cfg_index = '0;
	logic [tipc_pkg::WeightWidth-1:0] cfg_data = '0;
	logic                             in_valid = 1'b0;
	logic                             in_stall;
	tipc_pkg::in_beat_t               in_data = '0;
	logic                             out_valid;
	logic                             out_stall = 1'b0;
	tipc_pkg::out_beat_t              out_data;

	pixel_scoreboard                  pixels = new();
	bit                               steady = 1'b0;
	int                               stall_left = 0;
	int                               quiet_cycles = 0;
	logic [tipc_pkg::WeightWidth-1:0] blend_weights[8] = '{9'd0, 9'd1, 9'd128, 9'd255,
		9'd256, 9'd257, 9'd511, 9'd200};

	two_image_pixel_combiner DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data)
	);

	always #5 clk = ~clk;

	// The receiver holds stall for a random count of cycles after each accepted beat (none while steady is set).
	always @(negedge clk) begin
		if (stall_left > 0) begin
			out_stall <= 1'b1;
			stall_left <= stall_left - 1;
		end else begin
			out_stall <= 1'b0;
		end
	end

	always @(posedge clk) begin
		if (out_valid && !out_stall) begin
			pixels.check_pixel(out_data);
			stall_left <= steady ? 0 : $urandom_range(0, 7);
		end
		if (!arst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles + 1 >= QuietLimit) begin
			$display("*** FAILED ***");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	function logic [tipc_pkg::ChanWidth-1:0] rand_chan();
		logic [tipc_pkg::ChanWidth-1:0] edges[4] = '{8'd0, 8'd1, 8'd254, 8'd255};
		if ($urandom_range(0, 3) == 0)
			return edges[$urandom_range(0, 3)];
		return 8'($urandom_range(0, 255));
	endfunction

	function tipc_pkg::in_beat_t random_pixel();
		tipc_pkg::in_beat_t px;
		px.a_red = rand_chan();
		px.a_green = rand_chan();
		px.a_blue = rand_chan();
		px.b_red = rand_chan();
		px.b_green = rand_chan();
		px.b_blue = rand_chan();
		return px;
	endfunction

	// Called at a falling edge; returns at the falling edge after the beat is taken.
	task automatic send_pixel(input tipc_pkg::in_beat_t px);
		int gap;
		gap = steady ? 0 : $urandom_range(0, 7);
		repeat (gap) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		in_data <= px;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		pixels.note_pixel(px);
		@(negedge clk);
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		while (pixels.outstanding() != 0)
			@(posedge clk);
		@(negedge clk);
	endtask

	// Leaves cfg_we high; the caller lowers it once the last write is done.
	task automatic write_reg(input logic [tipc_pkg::IndexWidth-1:0] index,
			input logic [tipc_pkg::WeightWidth-1:0] data);
		cfg_we <= 1'b1;
		cfg_index <= index;
		cfg_data <= data;
		@(posedge clk);
		pixels.set_reg(index, data);
		@(negedge clk);
	endtask

	task automatic configure(input logic [2:0] mode_sel,
			input logic [tipc_pkg::WeightWidth-1:0] w);
		drain();
		// Upper data bits on a mode write must be dropped by the block.
		write_reg(tipc_pkg::RegMode, {6'($urandom_range(0, 63)), mode_sel});
		write_reg(tipc_pkg::RegWeight, w);
		write_reg($urandom_range(0, 1) ? RegSpareLow : RegSpareHigh,
			9'($urandom_range(0, 511)));
		cfg_we <= 1'b0;
		@(negedge clk);
	endtask

	initial begin
		tipc_pkg::in_beat_t corners[3];
		logic [2:0]         mode_sel;
		int                 p;
		int                 i;
		corners[0] = {8'd0, 8'd0, 8'd0, 8'd255, 8'd255, 8'd255};
		corners[1] = {8'd255, 8'd255, 8'd255, 8'd0, 8'd0, 8'd0};
		corners[2] = {8'd255, 8'd0, 8'd37, 8'd255, 8'd200, 8'd5};
		blend_weights[7] = 9'($urandom_range(2, 254));
		repeat (7) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Every mode on corner pixels; the first group runs on the reset settings.
		for (p = 0; p < 8; p++) begin
			if (p != 0) begin
				drain();
				write_reg(tipc_pkg::RegMode, {6'($urandom_range(0, 63)), 3'(p)});
				cfg_we <= 1'b0;
				@(negedge clk);
			end
			for (i = 0; i < 3; i++)
				send_pixel(corners[i]);
		end

		// Each mode once with a random weight, then the blend across the weight extremes.
		for (p = 0; p < PhaseCount; p++) begin
			if (p < 8)
				mode_sel = 3'(p);
			else
				mode_sel = tipc_pkg::MODE_BLEND;
			configure(mode_sel, (p < 8) ? 9'($urandom_range(0, 511)) : blend_weights[p - 8]);
			steady = ($urandom_range(0, 3) == 0);
			for (i = 0; i < PhaseBeats; i++) begin
				if (i == PhaseBeats / 2 && p % 2 == 1)
					drain();
				send_pixel(random_pixel());
			end
		end
		if (mode_sel == ModeUnused)
			steady = 1'b0;

		drain();
		repeat (SettleCycles) @(posedge clk);
		if (pixels.mismatches == 0 && pixels.outstanding() == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule

// File: sim.f
sv/tipc_pkg.sv
sv/tipc_lane.sv
sv/tipc_merge.sv
sv/two_image_pixel_combiner.sv
tb/testbench.sv
